/* hdl/uaps_pkg.sv */
`default_nettype none
package uaps_pkg;

   // Q0.32 turns per radian, round(2^32 / (2*pi)).
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   // 1e-6 rad in Q4.32.
   localparam logic [35:0] STRAIGHT_LIMIT = 36'd4295;
   // CORDIC start value, gain compensation in Q1.30.
   localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
   localparam logic [15:0] STEP_TIME_RESET = 16'd6554;
   localparam int DIV_NUM_W = 58;
   localparam int DIV_DEN_W = 21;

   // atan(2^-i) in turns, Q0.32.
   function automatic logic [31:0] atan_turns(input int idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // Carried alongside the half-angle CORDIC.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        new_heading;
      logic [31:0]        phi;
      logic [39:0]        m_straight;
      logic               straight;
      logic               speed_neg;
      logic [23:0]        speed_mag;
      logic [20:0]        rate_mag;
   } arc_side_type;

   // Carried alongside the chord divider.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        new_heading;
      logic [31:0]        phi;
      logic [39:0]        m_straight;
      logic               straight;
      logic               speed_neg;
   } div_side_type;

   // Carried alongside the heading CORDIC.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        new_heading;
      logic [57:0]        travel;
      logic               neg;
   } proj_side_type;

endpackage
`default_nettype wire

/* hdl/uaps_cordic.sv */
`default_nettype none
module uaps_cordic #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire logic [31:0]        in_angle,
   input  wire logic [SIDE_W-1:0]  in_side,
   output logic                    out_valid,
   output logic signed [32:0]      out_cos,
   output logic signed [32:0]      out_sin,
   output logic [SIDE_W-1:0]       out_side
);

   logic signed [32:0] x_ff [0:STAGES];
   logic signed [32:0] y_ff [0:STAGES];
   logic signed [32:0] z_ff [0:STAGES];
   logic [1:0]         quad_ff [0:STAGES];
   logic [SIDE_W-1:0]  side_ff [0:STAGES];
   logic               valid_ff [0:STAGES];

   // load: fold the angle into the first quadrant
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
      if (enable) begin
         x_ff[0]    <= uaps_pkg::CORDIC_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({3'b000, in_angle[29:0]});
         quad_ff[0] <= in_angle[31:30];
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [32:0] ATAN = $signed({1'b0, uaps_pkg::atan_turns(i)});
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (enable) begin
            if (!z_ff[i][32]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            quad_ff[i+1] <= quad_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // unfold the quadrant
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (enable) begin
         out_valid <= valid_ff[STAGES];
      end
      if (enable) begin
         out_side <= side_ff[STAGES];
         case (quad_ff[STAGES])
            2'd0: begin
               out_cos <= x_ff[STAGES];
               out_sin <= y_ff[STAGES];
            end
            2'd1: begin
               out_cos <= -y_ff[STAGES];
               out_sin <= x_ff[STAGES];
            end
            2'd2: begin
               out_cos <= -x_ff[STAGES];
               out_sin <= -y_ff[STAGES];
            end
            default: begin
               out_cos <= y_ff[STAGES];
               out_sin <= -x_ff[STAGES];
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* hdl/uaps_div.sv */
`default_nettype none
module uaps_div #(
   parameter int NUM_W  = 58,
   parameter int DEN_W  = 21,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quot,
   output logic [SIDE_W-1:0]      out_side
);

   // nq holds the unshifted numerator bits above and quotient bits below
   logic [NUM_W-1:0]  nq_ff   [0:NUM_W];
   logic [DEN_W-1:0]  rem_ff  [0:NUM_W];
   logic [DEN_W-1:0]  den_ff  [0:NUM_W];
   logic [SIDE_W-1:0] side_ff [0:NUM_W];
   logic              valid_ff [0:NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
      if (enable) begin
         nq_ff[0]   <= in_num;
         rem_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_bit
      logic [DEN_W:0] trial;
      logic           fits;
      assign trial = {rem_ff[k], nq_ff[k][NUM_W-1]};
      assign fits  = trial >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (enable) begin
            rem_ff[k+1]  <= fits ? DEN_W'(trial - {1'b0, den_ff[k]}) : trial[DEN_W-1:0];
            nq_ff[k+1]   <= {nq_ff[k][NUM_W-2:0], fits};
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quot  = nq_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];

endmodule
`default_nettype wire

/* hdl/unicycle_arc_pose_step.sv */
`default_nettype none
// Unicycle pose step: takes a pose (x, y, heading) with a speed and a turn
// rate and returns the pose one step_time later along a constant-curvature
// arc (a straight line when the heading change is below 1e-6 rad). The block
// is a single pipeline that takes one item every cycle while no result waits
// untaken at rsp_, and returns one result per item, in order. It has three
// stages for the heading change, a CORDIC for sin of the half angle, two
// stages for the chord numerator, a 58-stage restoring divider for the chord,
// a second CORDIC for the travel direction and three stages to project, add
// and saturate. The whole pipeline holds while a result waits at rsp_ and is
// not taken; no item is lost or repeated. step_time is written through the
// csr_ channel, which is always ready; write it only while the block is empty.
module unicycle_arc_pose_step #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_data,     // step_time
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // start_x[31:0], start_y[63:32], start_heading[79:64], speed[103:80],
   // turn_rate[124:104], zero fill [127:125]
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // new_x[31:0], new_y[63:32], new_heading[79:64]
   output logic [79:0]       rsp_tdata
);

   localparam int ARC_W  = $bits(uaps_pkg::arc_side_type);
   localparam int DIV_W  = $bits(uaps_pkg::div_side_type);
   localparam int PROJ_W = $bits(uaps_pkg::proj_side_type);

   logic        en;
   logic [15:0] step_time_ff;

   // Advance everything at once unless the finished result is stalled.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= uaps_pkg::STEP_TIME_RESET;
      end else if (csr_valid) begin
         step_time_ff <= csr_data;
      end
   end

   // Unpack the request item.
   logic signed [31:0] in_x, in_y;
   logic [15:0]        in_heading;
   logic signed [23:0] in_speed;
   logic signed [20:0] in_rate;
   logic signed [24:0] speed_ext;
   logic signed [21:0] rate_ext;
   logic [23:0]        speed_mag;
   logic [20:0]        rate_mag;

   assign in_x       = req_tdata[31:0];
   assign in_y       = req_tdata[63:32];
   assign in_heading = req_tdata[79:64];
   assign in_speed   = req_tdata[103:80];
   assign in_rate    = req_tdata[124:104];
   assign speed_ext  = 25'(in_speed);
   assign rate_ext   = 22'(in_rate);
   assign speed_mag  = in_speed[23] ? 24'(-speed_ext) : 24'(speed_ext);
   assign rate_mag   = in_rate[20] ? 21'(-rate_ext) : 21'(rate_ext);

   // Stage 1: heading change d = |w|*dt and straight distance |v|*dt.
   logic               s1_valid_ff;
   logic signed [31:0] s1_x_ff, s1_y_ff;
   logic [15:0]        s1_h_ff;
   logic               s1_vneg_ff, s1_wneg_ff;
   logic [23:0]        s1_vm_ff;
   logic [20:0]        s1_wm_ff;
   logic [35:0]        s1_am_ff;
   logic [39:0]        s1_mst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
      if (en) begin
         s1_x_ff    <= in_x;
         s1_y_ff    <= in_y;
         s1_h_ff    <= in_heading;
         s1_vneg_ff <= in_speed[23];
         s1_wneg_ff <= in_rate[20];
         s1_vm_ff   <= speed_mag;
         s1_wm_ff   <= rate_mag;
         s1_am_ff   <= 36'(rate_mag * step_time_ff);
         s1_mst_ff  <= 40'(speed_mag * step_time_ff);
      end
   end

   // Stage 2: radians to turns, split into high and low partial products.
   logic               s2_valid_ff;
   logic signed [31:0] s2_x_ff, s2_y_ff;
   logic [15:0]        s2_h_ff;
   logic               s2_vneg_ff, s2_wneg_ff, s2_straight_ff;
   logic [23:0]        s2_vm_ff;
   logic [20:0]        s2_wm_ff;
   logic [39:0]        s2_mst_ff;
   logic [49:0]        s2_phi_k_ff;
   logic [45:0]        s2_plo_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_x_ff        <= s1_x_ff;
         s2_y_ff        <= s1_y_ff;
         s2_h_ff        <= s1_h_ff;
         s2_vneg_ff     <= s1_vneg_ff;
         s2_wneg_ff     <= s1_wneg_ff;
         s2_vm_ff       <= s1_vm_ff;
         s2_wm_ff       <= s1_wm_ff;
         s2_mst_ff      <= s1_mst_ff;
         s2_straight_ff <= (s1_am_ff < uaps_pkg::STRAIGHT_LIMIT) || (s1_wm_ff == '0);
         s2_phi_k_ff    <= 50'(s1_am_ff[35:16] * uaps_pkg::INV_TWO_PI_Q32);
         s2_plo_k_ff    <= 46'(s1_am_ff[15:0] * uaps_pkg::INV_TWO_PI_Q32);
      end
   end

   // Stage 3: turns, new heading, half angle and travel direction.
   logic [46:0] lo_round;
   logic [50:0] dturn_sum;
   logic [34:0] dturn;
   logic [35:0] d16_round, ht_round;
   logic [15:0] d16, newh;
   logic [31:0] ht, phi_base, phi;

   assign lo_round  = 47'(s2_plo_k_ff) + 47'h80000000;
   assign dturn_sum = 51'(s2_phi_k_ff) + 51'(lo_round[46:16]);
   assign dturn     = dturn_sum[50:16];
   assign d16_round = 36'(dturn) + 36'h8000;
   assign d16       = d16_round[31:16];
   assign newh      = s2_wneg_ff ? s2_h_ff - d16 : s2_h_ff + d16;
   assign ht_round  = 36'(dturn) + 36'd1;
   assign ht        = ht_round[32:1];
   assign phi_base  = {s2_h_ff, 16'h0000};
   assign phi       = s2_straight_ff ? phi_base
                    : (s2_wneg_ff ? phi_base - ht : phi_base + ht);

   logic                   s3_valid_ff;
   logic [31:0]            s3_ht_ff;
   uaps_pkg::arc_side_type s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_ht_ff               <= ht;
         s3_side_ff.x           <= s2_x_ff;
         s3_side_ff.y           <= s2_y_ff;
         s3_side_ff.new_heading <= newh;
         s3_side_ff.phi         <= phi;
         s3_side_ff.m_straight  <= s2_mst_ff;
         s3_side_ff.straight    <= s2_straight_ff;
         s3_side_ff.speed_neg   <= s2_vneg_ff;
         s3_side_ff.speed_mag   <= s2_vm_ff;
         s3_side_ff.rate_mag    <= s2_wm_ff;
      end
   end

   // sin of the half angle; its cos is not needed.
   logic                   ca_valid;
   logic signed [32:0]     ca_sin;
   logic [ARC_W-1:0]       ca_side_vec;
   uaps_pkg::arc_side_type ca_side;

   uaps_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (ARC_W)
   ) u_cordic_half (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (s3_valid_ff),
      .in_angle  (s3_ht_ff),
      .in_side   (s3_side_ff),
      .out_valid (ca_valid),
      .out_cos   (),
      .out_sin   (ca_sin),
      .out_side  (ca_side_vec)
   );

   assign ca_side = ca_side_vec;

   // Stage 4: |v| * |sin(d/2)|.
   logic [32:0] sin_abs;
   assign sin_abs = ca_sin[32] ? 33'(-ca_sin) : 33'(ca_sin);

   logic                   s4_valid_ff;
   logic [55:0]            s4_prod_ff;
   uaps_pkg::arc_side_type s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= ca_valid;
      end
      if (en) begin
         s4_prod_ff <= 56'(ca_side.speed_mag * sin_abs[31:0]);
         s4_side_ff <= ca_side;
      end
   end

   // Stage 5: chord numerator 8*|v|*|S| + |w|/2, rounding the divide.
   logic                   s5_valid_ff;
   logic [57:0]            s5_num_ff;
   logic [20:0]            s5_den_ff;
   uaps_pkg::div_side_type s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (en) begin
         s5_num_ff              <= 58'({s4_prod_ff, 3'b000}) + 58'(s4_side_ff.rate_mag >> 1);
         s5_den_ff              <= s4_side_ff.rate_mag;
         s5_side_ff.x           <= s4_side_ff.x;
         s5_side_ff.y           <= s4_side_ff.y;
         s5_side_ff.new_heading <= s4_side_ff.new_heading;
         s5_side_ff.phi         <= s4_side_ff.phi;
         s5_side_ff.m_straight  <= s4_side_ff.m_straight;
         s5_side_ff.straight    <= s4_side_ff.straight;
         s5_side_ff.speed_neg   <= s4_side_ff.speed_neg;
      end
   end

   // Chord length = numerator / |w|.
   logic                   dv_valid;
   logic [57:0]            dv_quot;
   logic [DIV_W-1:0]       dv_side_vec;
   uaps_pkg::div_side_type dv_side;

   uaps_div #(
      .NUM_W  (uaps_pkg::DIV_NUM_W),
      .DEN_W  (uaps_pkg::DIV_DEN_W),
      .SIDE_W (DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_num_ff),
      .in_den    (s5_den_ff),
      .in_side   (s5_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side_vec)
   );

   assign dv_side = dv_side_vec;

   // Stage 6: pick the distance; an arc chord is never negated.
   logic                    s6_valid_ff;
   logic [31:0]             s6_phi_ff;
   uaps_pkg::proj_side_type s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= dv_valid;
      end
      if (en) begin
         s6_phi_ff              <= dv_side.phi;
         s6_side_ff.x           <= dv_side.x;
         s6_side_ff.y           <= dv_side.y;
         s6_side_ff.new_heading <= dv_side.new_heading;
         s6_side_ff.travel      <= dv_side.straight ? 58'(dv_side.m_straight) : dv_quot;
         s6_side_ff.neg         <= dv_side.straight && dv_side.speed_neg;
      end
   end

   // cos and sin of the travel direction.
   logic                    cb_valid;
   logic signed [32:0]      cb_cos, cb_sin;
   logic [PROJ_W-1:0]       cb_side_vec;
   uaps_pkg::proj_side_type cb_side;

   uaps_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (PROJ_W)
   ) u_cordic_dir (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (s6_valid_ff),
      .in_angle  (s6_phi_ff),
      .in_side   (s6_side_ff),
      .out_valid (cb_valid),
      .out_cos   (cb_cos),
      .out_sin   (cb_sin),
      .out_side  (cb_side_vec)
   );

   assign cb_side = cb_side_vec;

   // Stage 7: distance times |cos| and |sin|, split at bit 28.
   logic [32:0] cos_abs, sin2_abs;
   assign cos_abs  = cb_cos[32] ? 33'(-cb_cos) : 33'(cb_cos);
   assign sin2_abs = cb_sin[32] ? 33'(-cb_sin) : 33'(cb_sin);

   logic               s7_valid_ff;
   logic [61:0]        s7_chi_ff, s7_shi_ff;
   logic [59:0]        s7_clo_ff, s7_slo_ff;
   logic               s7_cneg_ff, s7_sneg_ff;
   logic signed [31:0] s7_x_ff, s7_y_ff;
   logic [15:0]        s7_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s7_valid_ff <= cb_valid;
      end
      if (en) begin
         s7_chi_ff  <= 62'(cb_side.travel[57:28] * cos_abs[31:0]);
         s7_clo_ff  <= 60'(cb_side.travel[27:0] * cos_abs[31:0]);
         s7_shi_ff  <= 62'(cb_side.travel[57:28] * sin2_abs[31:0]);
         s7_slo_ff  <= 60'(cb_side.travel[27:0] * sin2_abs[31:0]);
         s7_cneg_ff <= cb_cos[32] != cb_side.neg;
         s7_sneg_ff <= cb_sin[32] != cb_side.neg;
         s7_x_ff    <= cb_side.x;
         s7_y_ff    <= cb_side.y;
         s7_h_ff    <= cb_side.new_heading;
      end
   end

   // Stage 8: round the displacements to Q16.16 and apply the sign.
   logic [60:0] clo_round, slo_round;
   logic [62:0] csum, ssum;
   logic [45:0] cmag, smag;

   assign clo_round = 61'(s7_clo_ff) + (61'd1 << 45);
   assign slo_round = 61'(s7_slo_ff) + (61'd1 << 45);
   assign csum      = 63'(s7_chi_ff) + 63'(clo_round[60:28]);
   assign ssum      = 63'(s7_shi_ff) + 63'(slo_round[60:28]);
   assign cmag      = {1'b0, csum[62:18]};
   assign smag      = {1'b0, ssum[62:18]};

   logic               s8_valid_ff;
   logic signed [45:0] s8_dx_ff, s8_dy_ff;
   logic signed [31:0] s8_x_ff, s8_y_ff;
   logic [15:0]        s8_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s8_valid_ff <= s7_valid_ff;
      end
      if (en) begin
         s8_dx_ff <= s7_cneg_ff ? -$signed(cmag) : $signed(cmag);
         s8_dy_ff <= s7_sneg_ff ? -$signed(smag) : $signed(smag);
         s8_x_ff  <= s7_x_ff;
         s8_y_ff  <= s7_y_ff;
         s8_h_ff  <= s7_h_ff;
      end
   end

   // Stage 9: add at full width, saturate, and hold for the consumer.
   logic signed [46:0] x_sum, y_sum;
   logic [31:0]        x_sat, y_sat;

   assign x_sum = 47'(s8_x_ff) + 47'(s8_dx_ff);
   assign y_sum = 47'(s8_y_ff) + 47'(s8_dy_ff);

   always_comb begin
      if (x_sum[46:31] == '0 || x_sum[46:31] == '1) begin
         x_sat = x_sum[31:0];
      end else begin
         x_sat = x_sum[46] ? 32'h80000000 : 32'h7FFFFFFF;
      end
      if (y_sum[46:31] == '0 || y_sum[46:31] == '1) begin
         y_sat = y_sum[31:0];
      end else begin
         y_sat = y_sum[46] ? 32'h80000000 : 32'h7FFFFFFF;
      end
   end

   logic        rsp_valid_ff;
   logic [79:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s8_valid_ff;
      end
      if (en) begin
         rsp_data_ff <= {s8_h_ff, y_sat, x_sat};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam int STAGES      = 16;
   localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the pipeline
   localparam int STALL_LIMIT = 4000;  // cycles without any handshake before giving up
   localparam int DRAIN_WAIT  = 120;   // wait after draining, beyond the pipeline latency

   typedef struct packed {
      logic [15:0] heading;
      logic [31:0] y;
      logic [31:0] x;
   } pose_type;

   // Pose integrator prediction plus the in-order store of expected poses.
   class pose_scoreboard;
      pose_type    expected_poses[$];
      logic [15:0] step_time;
      int          errors;

      function new();
         step_time = uaps_pkg::STEP_TIME_RESET;
         errors    = 0;
      endfunction

      static function longint unsigned mag64(longint v);
         return (v < 0) ? longint'(-v) : longint'(v);
      endfunction

      // Rotation CORDIC on the angle within its quadrant, then quadrant swap.
      static function void sin_cos(input logic [31:0] ang, output longint c,
                                   output longint s);
         longint x, y, z, xs, ys;
         longint rot [24];
         rot = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                 64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                 64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
         x = uaps_pkg::CORDIC_START;
         y = 0;
         z = {34'd0, ang[29:0]};
         for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - rot[i];
            end else begin
               x = x + ys; y = y - xs; z = z + rot[i];
            end
         end
         case (ang[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
      endfunction

      // Scale a Q32 distance by a Q1.30 direction component down to Q16.16.
      static function longint project(longint unsigned travel, longint k, bit flip);
         longint unsigned km, hi, lo, r;
         km = mag64(k);
         hi = travel >> 28;
         lo = travel & 64'h0FFF_FFFF;
         r  = (hi * km + ((lo * km + (64'd1 << 45)) >> 28)) >> 18;
         return ((k < 0) != flip) ? -longint'(r) : longint'(r);
      endfunction

      static function logic [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v[31:0];
      endfunction

      function void note_request(logic [127:0] d);
         longint sx, sy, v, w, c, s, hc, hs;
         longint unsigned vm, wm, dt, am, hi, lo, dturn, travel;
         logic [15:0] h, d16;
         logic [31:0] phi, ht;
         bit flip;
         pose_type p;
         sx = $signed(d[31:0]);
         sy = $signed(d[63:32]);
         h  = d[79:64];
         v  = $signed(d[103:80]);
         w  = $signed(d[124:104]);
         vm = mag64(v);
         wm = mag64(w);
         dt = step_time;
         am = wm * dt;
         hi = am >> 16;
         lo = am & 64'hFFFF;
         dturn = (hi * uaps_pkg::INV_TWO_PI_Q32
                  + ((lo * uaps_pkg::INV_TWO_PI_Q32 + 64'h8000_0000) >> 16)) >> 16;
         d16 = 16'((dturn + 64'h8000) >> 16);
         p.heading = (w < 0) ? h - d16 : h + d16;
         phi = {h, 16'h0000};
         if (am < uaps_pkg::STRAIGHT_LIMIT || wm == 0) begin
            travel = vm * dt;
            flip = (v < 0);
         end else begin
            ht  = 32'((dturn + 1) >> 1);
            phi = (w < 0) ? phi - ht : phi + ht;
            sin_cos(ht, hc, hs);
            travel = (vm * mag64(hs) * 8 + wm / 2) / wm;
            flip = 1'b0;
         end
         sin_cos(phi, c, s);
         p.x = clamp32(sx + project(travel, c, flip));
         p.y = clamp32(sy + project(travel, s, flip));
         expected_poses.insert(expected_poses.size(), p);
      endfunction

      function void check_response(logic [79:0] d);
         pose_type e;
         if (expected_poses.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
         end
         e = expected_poses.pop_front();
         if (d[31:0] !== e.x) begin
            $display("%0t: new_x expected %h actual %h", $time, e.x, d[31:0]);
            errors++;
         end
         if (d[63:32] !== e.y) begin
            $display("%0t: new_y expected %h actual %h", $time, e.y, d[63:32]);
            errors++;
         end
         if (d[79:64] !== e.heading) begin
            $display("%0t: new_heading expected %h actual %h", $time, e.heading, d[79:64]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   wire          csr_ready;
   logic [15:0]  csr_data = '0;
   logic         req_tvalid = 1'b0;
   wire          req_tready;
   logic [127:0] req_tdata = '0;
   wire          rsp_tvalid;
   logic         rsp_tready = 1'b0;
   wire  [79:0]  rsp_tdata;

   pose_scoreboard sb = new();

   int send_idle_pct  = 0;   // chance per cycle that the sender holds off
   int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
   bit hold_req = 1'b0;      // ask the receiver for one long hold-off
   int hold_left = 0;
   int quiet_cycles = 0;

   unicycle_arc_pose_step u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: stall at random, or hold off for a long stretch when asked.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check every result item as it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [127:0] pack_pose(logic [31:0] x, logic [31:0] y,
                                              logic [15:0] h, logic [23:0] v,
                                              logic [20:0] w);
      return {3'b000, w, v, h, y, x};
   endfunction

   // Mix extremes, small values and full-range values; the heading is always full-range.
   function automatic logic [127:0] random_pose();
      logic [31:0] x, y;
      logic [23:0] v;
      logic [20:0] w;
      x = $urandom;
      y = $urandom;
      if ($urandom_range(7) == 0) x = {~x[31], {31{x[31]}}} ^ 32'($urandom_range(3));
      if ($urandom_range(7) == 0) y = {~y[31], {31{y[31]}}} ^ 32'($urandom_range(3));
      v = $urandom;
      if ($urandom_range(3) == 0) v = 24'($signed(v[17:0]));
      if ($urandom_range(15) == 0) v = '0;
      w = $urandom;
      case ($urandom_range(7))
         0: w = '0;
         1: w = 21'($signed(5'($urandom)));
         2: w = 21'($signed(14'($urandom)));
         default: ;
      endcase
      return pack_pose(x, y, 16'($urandom), v, w);
   endfunction

   task automatic send_pose(logic [127:0] d);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(d);
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected pose has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_poses.size() != 0) @(negedge clock);
   endtask

   task automatic write_step_time(logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.step_time = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count, int idle, int stall);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (count) send_pose(random_pose());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items at the reset step time.
      send_pose(pack_pose('0, '0, '0, '0, '0));
      send_pose(pack_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 24'h7FFFFF, '0));
      send_pose(pack_pose(32'h8000_0000, 32'h8000_0000, 16'h8000, 24'h7FFFFF, '0));
      send_pose(pack_pose(32'h0001_0000, 32'hFFFF_0000, 16'h4000, 24'h800000, '0));
      send_pose(pack_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'hC000, 24'h7FFFFF, 21'h0FFFFF));
      send_pose(pack_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h2000, 24'h800000, 21'h100000));
      send_pose(pack_pose(32'h1234_5678, 32'h8765_4321, 16'h1000, '0, 21'd1000));
      send_pose(pack_pose('0, '0, 16'hFFFF, 24'h010000, 21'd65536));
      send_pose(pack_pose('0, '0, 16'h0000, 24'h010000, -21'sd65536));
      send_pose(pack_pose('0, '0, 16'h4000, 24'h010000, 21'd1));
      send_pose(pack_pose('0, '0, 16'h4000, 24'h800000, -21'sd1));
      send_pose(pack_pose(32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, 24'hFFFFFF, 21'h1FFFFF));

      // Zero step time: straight, zero distance, heading unchanged.
      write_step_time(16'd0);
      send_pose(pack_pose(32'h0100_0000, 32'hFF00_0000, 16'h7777, 24'h7FFFFF, 21'h0FFFFF));
      send_pose(pack_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h8001, 24'h800000, 21'h100000));

      // Smallest step: straight just below the arc threshold, arc just above it.
      write_step_time(16'd1);
      send_pose(pack_pose('0, '0, 16'h2000, 24'h7FFFFF, 21'd4294));
      send_pose(pack_pose('0, '0, 16'h2000, 24'h7FFFFF, 21'd4295));
      send_pose(pack_pose('0, '0, 16'hE000, 24'h800000, -21'sd4295));
      random_phase(150, 0, 0);

      write_step_time(16'hFFFF);
      random_phase(300, 75, 0);

      // Long receiver hold-off while the sender keeps offering.
      write_step_time(uaps_pkg::STEP_TIME_RESET);
      hold_req = 1'b1;
      random_phase(300, 0, 0);
      random_phase(150, 0, 75);

      write_step_time(16'($urandom_range(65535, 1)));
      random_phase(300, 7, 7);

      write_step_time(16'h8000);
      random_phase(350, 0, 0);

      write_step_time(16'($urandom_range(65535, 1)));
      random_phase(350, 75, 75);

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0 && sb.expected_poses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
